### src/lgu_pkg.sv
`timescale 1ns / 1ps
// shared constants, character tables and divide-by-45 helpers for the url prefix block
// no dependencies

package lgu_pkg;

	localparam int unsigned COORD_BITS_DEF      = 30;
	localparam int unsigned MAX_POINT_CHARS_DEF = 10;
	localparam logic [3:0]  POINT_CHARS_RST     = 4'd9;

	// one degree is 2^22 units
	localparam logic signed [33:0] LAT_HALF  = 34'sd377487360;   // 90 deg
	localparam logic signed [33:0] LON_HALF  = 34'sd754974720;   // 180 deg
	localparam logic signed [33:0] LON_WRAP  = 34'sd2264924160;  // 540 deg

	localparam logic [15:0] ZOOM_LO = 16'd1024;
	localparam logic [15:0] ZOOM_HI = 16'd5056;
	localparam logic [5:0]  ZOOM_MAX_CODE = 6'd63;

	// span divisors are 45 * 2^k, the power of two is taken apart by shifts
	localparam int unsigned DIV45      = 45;
	localparam logic [5:0]  DIV45_6    = 6'd45;
	localparam int unsigned RECIP_SHIFT = 37;
	localparam logic [31:0] RECIP45    = 32'((64'd1 << RECIP_SHIFT) / DIV45 + 64'd1);

	localparam logic [31:0] LAT_BIAS = 32'd16777216;  // 2^24
	localparam logic [31:0] LON_BIAS = 32'd33554432;  // 2^25

	// character positions inside one prefix
	localparam int unsigned SCHEME_LEN = 6;
	localparam int unsigned ZOOM_POS   = 6;

	typedef logic [31:0] frac_tab_t [64];

	// floor(2*b*(2^cb-1)/45) for each remainder b
	function automatic frac_tab_t lat_frac_tab(input int cb);
		frac_tab_t t;
		longint unsigned m;
		m = (64'd1 << cb) - 64'd1;
		for (int b = 0; b < 64; b++) begin
			if (b < 45) t[b] = 32'((64'(b) * 64'd2 * m) / DIV45);
			else t[b] = '0;
		end
		return t;
	endfunction

	// floor(b*2^(cb+1)/45) for each remainder b
	function automatic frac_tab_t lon_frac_tab(input int cb);
		frac_tab_t t;
		for (int b = 0; b < 64; b++) begin
			if (b < 45) t[b] = 32'((64'(b) << (cb + 1)) / DIV45);
			else t[b] = '0;
		end
		return t;
	endfunction

	// url-safe base64 alphabet
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] c;
		case (v) inside
			[6'd0:6'd25]:  c = 7'd65 + 7'(v);
			[6'd26:6'd51]: c = 7'd71 + 7'(v);
			[6'd52:6'd61]: c = 7'(v) - 7'd4;
			6'd62:         c = 7'd45;
			default:       c = 7'd95;
		endcase
		return c;
	endfunction

	// fixed scheme text ahead of the zoom character
	function automatic logic [6:0] scheme_char(input logic [2:0] pos);
		logic [6:0] c;
		case (pos)
			3'd0:    c = 7'h67;
			3'd1:    c = 7'h65;
			3'd2:    c = 7'h30;
			3'd3:    c = 7'h3a;
			3'd4:    c = 7'h2f;
			3'd5:    c = 7'h2f;
			default: c = 7'h00;
		endcase
		return c;
	endfunction

endpackage

### src/latlon_geocode_url_prefix.sv
`timescale 1ns / 1ps
// url prefix generator: five-stage coordinate pipeline and a character serializer
// depends on lgu_pkg

// Each request (latitude, longitude, zoom) produces 7 + point_chars ASCII characters, one
// per cycle on the output channel while out_ready is high, the last one flagged by
// last_char: 16 characters at the default point_chars of 9. The character serializer at
// the end limits throughput; the five coordinate stages ahead of it take a new request
// every cycle unless stalled, and the serializer picks up the next request in the same
// cycle as it registers the last character of the previous one, so back-to-back requests
// stream without gaps. Latitudes beyond +-90 clamp, longitudes wrap into [-180,180).
// point_chars (cfg_wr_data) is to be written by the user only while no request is in flight,
// which the block does not enforce; values above MAX_POINT_CHARS behave as MAX_POINT_CHARS.
module latlon_geocode_url_prefix #(
	parameter int unsigned COORD_BITS      = lgu_pkg::COORD_BITS_DEF,
	parameter int unsigned MAX_POINT_CHARS = lgu_pkg::MAX_POINT_CHARS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [3:0]         cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] latitude,
	input  logic signed [31:0] longitude,
	input  logic [15:0]        zoom_level,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [6:0]         char_code,
	output logic               last_char
);

	localparam int unsigned CB    = COORD_BITS;
	localparam int unsigned AW    = CB + 27;
	localparam int unsigned SW    = CB + 28;
	localparam int unsigned W     = 3 * MAX_POINT_CHARS;
	localparam int unsigned IDX_W = $clog2(MAX_POINT_CHARS + 7);

	localparam lgu_pkg::frac_tab_t LAT_FRAC = lgu_pkg::lat_frac_tab(COORD_BITS);
	localparam lgu_pkg::frac_tab_t LON_FRAC = lgu_pkg::lon_frac_tab(COORD_BITS);

	// ---------------- configuration
	logic [3:0] point_chars_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_chars_q <= lgu_pkg::POINT_CHARS_RST;
		end else if (cfg_wr_en) begin
			point_chars_q <= cfg_wr_data;
		end
	end

	// ---------------- stage handshake
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic ser_ready;

	assign rdy5     = !v_s5 || ser_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// ---------------- stage 1: offset, clamp flags, longitude wrap, zoom code
	logic signed [33:0] lat_ext, lon_ext;
	logic signed [33:0] lat_off, lon_mid, lon_lo, lon_hi;
	logic [15:0]        zdiff;
	logic [5:0]         zcode;

	logic [30:0] lat_n_s1, lon_p_s1;
	logic        lat_lo_s1, lat_hi_s1;
	logic [5:0]  zcode_s1;

	assign lat_ext = {{2{latitude[31]}}, latitude};
	assign lon_ext = {{2{longitude[31]}}, longitude};
	assign lat_off = lat_ext + lgu_pkg::LAT_HALF;
	assign lon_mid = lon_ext + lgu_pkg::LON_HALF;
	assign lon_lo  = lon_ext + lgu_pkg::LON_WRAP;
	assign lon_hi  = lon_ext - lgu_pkg::LON_HALF;
	assign zdiff   = zoom_level - lgu_pkg::ZOOM_LO;

	always_comb begin
		if (zoom_level <= lgu_pkg::ZOOM_LO) zcode = '0;
		else if (zoom_level >= lgu_pkg::ZOOM_HI) zcode = lgu_pkg::ZOOM_MAX_CODE;
		else zcode = zdiff[11:6];
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			lat_lo_s1 <= lat_ext < -lgu_pkg::LAT_HALF;
			lat_hi_s1 <= lat_ext > lgu_pkg::LAT_HALF;
			lat_n_s1  <= (lat_ext < -lgu_pkg::LAT_HALF || lat_ext > lgu_pkg::LAT_HALF) ?
				'0 : lat_off[30:0];
			if (lon_ext < -lgu_pkg::LON_HALF) lon_p_s1 <= lon_lo[30:0];
			else if (lon_ext >= lgu_pkg::LON_HALF) lon_p_s1 <= lon_hi[30:0];
			else lon_p_s1 <= lon_mid[30:0];
			zcode_s1 <= zcode;
		end
	end

	// ---------------- stage 2: reciprocal multiply for the quotient by 45
	logic [62:0] lat_prod_s2, lon_prod_s2;
	logic [5:0]  lat_nlo_s2, lon_plo_s2;
	logic        lat_lo_s2, lat_hi_s2;
	logic [5:0]  zcode_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			lat_prod_s2 <= {32'd0, lat_n_s1} * {31'd0, lgu_pkg::RECIP45};
			lon_prod_s2 <= {32'd0, lon_p_s1} * {31'd0, lgu_pkg::RECIP45};
			lat_nlo_s2  <= lat_n_s1[5:0];
			lon_plo_s2  <= lon_p_s1[5:0];
			lat_lo_s2   <= lat_lo_s1;
			lat_hi_s2   <= lat_hi_s1;
			zcode_s2    <= zcode_s1;
		end
	end

	// ---------------- stage 3: quotient and remainder (remainder fits in 6 bits)
	logic [25:0] lat_a, lon_a;
	logic [5:0]  lat_a45, lon_a45;

	logic [25:0] lat_a_s3, lon_a_s3;
	logic [5:0]  lat_b_s3, lon_b_s3;
	logic        lat_lo_s3, lat_hi_s3;
	logic [5:0]  zcode_s3;

	assign lat_a   = lat_prod_s2[62:37];
	assign lon_a   = lon_prod_s2[62:37];
	assign lat_a45 = 6'(lat_a[5:0] * lgu_pkg::DIV45_6);
	assign lon_a45 = 6'(lon_a[5:0] * lgu_pkg::DIV45_6);

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			lat_a_s3  <= lat_a;
			lon_a_s3  <= lon_a;
			lat_b_s3  <= lat_nlo_s2 - lat_a45;
			lon_b_s3  <= lon_plo_s2 - lon_a45;
			lat_lo_s3 <= lat_lo_s2;
			lat_hi_s3 <= lat_hi_s2;
			zcode_s3  <= zcode_s2;
		end
	end

	// ---------------- stage 4: scaled quotient and remainder fraction
	logic [AW-1:0] lat_am2_s4;
	logic [25:0]   lon_a_s4;
	logic [31:0]   lat_frac_s4, lon_frac_s4;
	logic          lat_lo_s4, lat_hi_s4;
	logic [5:0]    zcode_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			// 2*a*(2^cb - 1)
			lat_am2_s4  <= {lat_a_s3, {(CB + 1){1'b0}}} - AW'({lat_a_s3, 1'b0});
			lat_frac_s4 <= LAT_FRAC[lat_b_s3] + lgu_pkg::LAT_BIAS;
			lon_a_s4    <= lon_a_s3;
			lon_frac_s4 <= LON_FRAC[lon_b_s3] + lgu_pkg::LON_BIAS;
			lat_lo_s4   <= lat_lo_s3;
			lat_hi_s4   <= lat_hi_s3;
			zcode_s4    <= zcode_s3;
		end
	end

	// ---------------- stage 5: final sums, clamp and wrap-around select
	logic [SW-1:0] lat_sum, lon_sum;
	logic [CB:0]   lon_q;

	logic [CB-1:0] lat_code_s5, lon_code_s5;
	logic [5:0]    zcode_s5;

	assign lat_sum = SW'(lat_am2_s4) + SW'(lat_frac_s4);
	assign lon_sum = SW'({lon_a_s4, {(CB + 1){1'b0}}}) + SW'(lon_frac_s4);
	assign lon_q   = lon_sum[CB + 26:26];

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			if (lat_lo_s4) lat_code_s5 <= '0;
			else if (lat_hi_s4) lat_code_s5 <= '1;
			else lat_code_s5 <= lat_sum[CB + 24:25];
			// a full turn maps back to zero
			lon_code_s5 <= lon_q[CB] ? '0 : lon_q[CB-1:0];
			zcode_s5    <= zcode_s4;
		end
	end

	// ---------------- character serializer
	logic               busy_q;
	logic [IDX_W-1:0]   idx_q, last_idx_q;
	logic [W-1:0]       lat_sh_q, lon_sh_q;
	logic [5:0]         zc_q;
	logic               out_valid_q;
	logic [6:0]         char_code_q;
	logic               last_char_q;

	logic               out_load, last_now, ser_load;
	logic [3:0]         n_sat;
	logic [CB+W-1:0]    lat_ext_code, lon_ext_code;
	logic [5:0]         pt_val;
	logic [6:0]         cur_char;

	assign out_load  = busy_q && (!out_valid_q || out_ready);
	assign last_now  = idx_q == last_idx_q;
	assign ser_ready = !busy_q || (out_load && last_now);
	assign ser_load  = ser_ready && v_s5;

	assign n_sat = (point_chars_q > 4'(MAX_POINT_CHARS)) ? 4'(MAX_POINT_CHARS) : point_chars_q;
	// code aligned so its top bit leads the window, zero bits below its lsb
	assign lat_ext_code = {lat_code_s5, {W{1'b0}}};
	assign lon_ext_code = {lon_code_s5, {W{1'b0}}};

	assign pt_val = {lat_sh_q[W-1], lon_sh_q[W-1], lat_sh_q[W-2], lon_sh_q[W-2],
		lat_sh_q[W-3], lon_sh_q[W-3]};

	always_comb begin
		if (idx_q < IDX_W'(lgu_pkg::SCHEME_LEN)) cur_char = lgu_pkg::scheme_char(idx_q[2:0]);
		else if (idx_q == IDX_W'(lgu_pkg::ZOOM_POS)) cur_char = lgu_pkg::b64_char(zc_q);
		else cur_char = lgu_pkg::b64_char(pt_val);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ser_load) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (out_load) begin
				if (last_now) busy_q <= 1'b0;
				idx_q <= idx_q + 1'b1;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_load) begin
			lat_sh_q   <= lat_ext_code[CB+W-1 -: W];
			lon_sh_q   <= lon_ext_code[CB+W-1 -: W];
			zc_q       <= zcode_s5;
			last_idx_q <= IDX_W'(lgu_pkg::SCHEME_LEN) + IDX_W'(n_sat);
		end else if (out_load && idx_q > IDX_W'(lgu_pkg::ZOOM_POS)) begin
			lat_sh_q <= lat_sh_q << 3;
			lon_sh_q <= lon_sh_q << 3;
		end
		if (out_load) begin
			char_code_q <= cur_char;
			last_char_q <= last_now;
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_code_q;
	assign last_char = last_char_q;

	// ---------------- assertions
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (lat_b_s3 < lgu_pkg::DIV45_6) && (lon_b_s3 < lgu_pkg::DIV45_6))
		else $error("remainder by 45 out of range");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= last_idx_q)
		else $error("character index past end of prefix");

	a_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_now) |=> (!busy_q || idx_q == '0))
		else $error("serializer did not restart after last character");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && !ser_ready) |=> (v_s5 && $stable(lat_code_s5) && $stable(lon_code_s5)))
		else $error("stalled request lost in last stage");

endmodule

### verif/tb_latlon_geocode_url_prefix.sv
`timescale 1ns / 1ps
// testbench for latlon_geocode_url_prefix: directed and random requests, every prefix character
// checked against an in-bench predictor under varied idle, stall and hold-off patterns
// depends on lgu_pkg and latlon_geocode_url_prefix

module tb_latlon_geocode_url_prefix;

	localparam int CB            = lgu_pkg::COORD_BITS_DEF;
	localparam int MPC           = lgu_pkg::MAX_POINT_CHARS_DEF;
	localparam longint DEG       = longint'(1) << 22;
	localparam int LAT_SPAN      = 90 << 22;
	localparam int LON_SPAN      = 180 << 22;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct packed {
		logic [6:0] code;
		logic       last;
	} prefix_char_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [3:0]         cfg_wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] latitude = '0;
	logic signed [31:0] longitude = '0;
	logic [15:0]        zoom_level = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [6:0]         char_code;
	logic               last_char;

	prefix_char_t char_queue[$];
	logic [3:0]   point_chars_reg = lgu_pkg::POINT_CHARS_RST;
	int           errors = 0;
	int           requests_sent = 0;
	int           chars_checked = 0;
	int           cycles = 0;
	int           gap_pct = 0;
	int           stall_pct = 0;
	int           hold_len = 0;
	string        b64_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

	latlon_geocode_url_prefix #(
		.COORD_BITS(CB),
		.MAX_POINT_CHARS(MPC)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.latitude(latitude),
		.longitude(longitude),
		.zoom_level(zoom_level),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_code(char_code),
		.last_char(last_char)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// latitude clamped to +-90 and rounded half up onto the grid
	function automatic longint lat_grid(input logic signed [31:0] lat);
		longint m, d, n;
		m = (longint'(1) << CB) - 1;
		d = 180 * DEG;
		n = longint'(lat) + 90 * DEG;
		if (n < 0) return 0;
		if (n > d) return m;
		return (2 * n * m + d) / (2 * d);
	endfunction

	// longitude wrapped into [-180,180) then scaled onto 2^CB steps
	function automatic longint lon_grid(input logic signed [31:0] lon);
		longint m1, e, p, q;
		m1 = longint'(1) << CB;
		e = 360 * DEG;
		p = (longint'(lon) + 180 * DEG) % e;
		if (p < 0) p += e;
		q = (2 * p * m1 + e) / (2 * e);
		return (q >= m1) ? 0 : q;
	endfunction

	function automatic logic [2:0] bit_group(input longint v, input int shift);
		if (shift >= 0) return 3'((v >> shift) & 7);
		return 3'((v << -shift) & 7);
	endfunction

	function automatic void predict_prefix(input logic signed [31:0] lat,
		input logic signed [31:0] lon, input logic [15:0] zoom);
		logic [6:0]   scheme [6];
		longint       la, lo;
		int           count;
		logic [5:0]   zcode, v;
		logic [2:0]   a, b;
		prefix_char_t c;
		// scheme text, colon and two slashes
		scheme = '{7'h67, 7'h65, 7'h30, 7'h3a, 7'h2f, 7'h2f};
		count = (point_chars_reg > MPC) ? MPC : int'(point_chars_reg);
		for (int i = 0; i < 6; i++) begin
			c.code = scheme[i];
			c.last = 1'b0;
			char_queue.push_back(c);
		end
		if (zoom <= lgu_pkg::ZOOM_LO) zcode = '0;
		else if (zoom >= lgu_pkg::ZOOM_HI) zcode = lgu_pkg::ZOOM_MAX_CODE;
		else zcode = 6'((zoom - lgu_pkg::ZOOM_LO) >> 6);
		c.code = 7'(b64_set[zcode]);
		c.last = (count == 0);
		char_queue.push_back(c);
		la = lat_grid(lat);
		lo = lon_grid(lon);
		for (int i = 0; i < count; i++) begin
			a = bit_group(la, CB - 3 - 3 * i);
			b = bit_group(lo, CB - 3 - 3 * i);
			v = {a[2], b[2], a[1], b[1], a[0], b[0]};
			c.code = 7'(b64_set[v]);
			c.last = (i == count - 1);
			char_queue.push_back(c);
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch %s at char %0d: got %0d, want %0d", what, chars_checked, got, want);
	endtask

	// called in a rising-edge step, returns in the step where the request was taken
	task automatic send_fix(input logic signed [31:0] lat, input logic signed [31:0] lon,
		input logic [15:0] zoom);
		logic taken;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		latitude <= lat;
		longitude <= lon;
		zoom_level <= zoom;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		predict_prefix(lat, lon, zoom);
		requests_sent++;
	endtask

	// in-range coordinates for most latitudes and half the longitudes, the rest full-range to hit clamping and wrapping
	task automatic send_random();
		logic signed [31:0] lat, lon;
		logic [15:0]        zoom;
		if ($urandom_range(9) < 6) lat = 32'($urandom_range(2 * LAT_SPAN)) - LAT_SPAN;
		else lat = $urandom();
		if ($urandom_range(9) < 5) lon = 32'($urandom_range(2 * LON_SPAN - 1)) - LON_SPAN;
		else lon = $urandom();
		if ($urandom_range(1)) zoom = 16'($urandom_range(lgu_pkg::ZOOM_HI, lgu_pkg::ZOOM_LO));
		else zoom = 16'($urandom());
		send_fix(lat, lon, zoom);
	endtask

	task automatic drain_block();
		in_valid <= 1'b0;
		while (char_queue.size() != 0) @(posedge clk);
	endtask

	task automatic set_point_chars(input logic [3:0] value);
		drain_block();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		point_chars_reg = value;
	endtask

	// runs at the reset value of point_chars, so no register write first
	task automatic test_zoom_codes();
		logic [15:0] zooms [8] = '{16'd0, 16'd1024, 16'd1025, 16'd1088, 16'd1089, 16'd5055,
			16'd5056, 16'hffff};
		gap_pct = 0;
		stall_pct = 0;
		foreach (zooms[i]) send_fix((i % 2) ? -32'sd1 : 32'sd0, (i % 2) ? 32'sd1 : 32'sd0,
			zooms[i]);
	endtask

	task automatic test_coordinate_edges();
		logic signed [31:0] lats [8] = '{32'h80000000, 32'h7fffffff, -LAT_SPAN, LAT_SPAN,
			LAT_SPAN + 1, -LAT_SPAN - 1, 32'sd0, 32'sd0};
		logic signed [31:0] lons [8] = '{32'h80000000, 32'h7fffffff, -LON_SPAN, LON_SPAN,
			LON_SPAN - 1, -LON_SPAN - 1, 2 * LON_SPAN, -2 * LON_SPAN};
		set_point_chars(4'd10);
		foreach (lats[i]) send_fix(lats[i], lons[i], lgu_pkg::ZOOM_HI);
	endtask

	// no position characters, one, and counts above the maximum that saturate
	task automatic test_point_counts();
		set_point_chars(4'd0);
		send_fix(32'sd12345678, -32'sd87654321, 16'd3000);
		set_point_chars(4'd1);
		send_fix(-32'sd12345678, 32'sd87654321, 16'd2000);
		set_point_chars(4'd15);
		send_fix(32'sd300000000, -32'sd700000000, 16'd4500);
		set_point_chars(4'd11);
		send_fix(-32'sd300000000, 32'sd700000000, 16'd1500);
	endtask

	// long output hold while requests keep coming, so the input side backs up
	task automatic test_output_backpressure();
		set_point_chars(4'd10);
		gap_pct = 0;
		stall_pct = 0;
		hold_len = 300;
		repeat (24) send_random();
	endtask

	task automatic test_random_phase(input int gap, input int stall, input logic [3:0] count,
		input int items);
		set_point_chars(count);
		gap_pct = gap;
		stall_pct = stall;
		repeat (items) send_random();
	endtask

	initial begin : receiver
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				out_ready <= 1'b0;
				hold_len--;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// handshake values are stable at the falling edge and hold until the next rising edge
	initial begin : result_check
		prefix_char_t want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (char_queue.size() == 0) begin
					report_mismatch("unexpected char", char_code, -1);
				end else begin
					want = char_queue.pop_front();
					if (char_code !== want.code) report_mismatch("char_code", char_code, want.code);
					if (last_char !== want.last) report_mismatch("last_char", last_char, want.last);
				end
				chars_checked++;
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d chars still pending", cycles, char_queue.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zoom_codes();
		test_coordinate_edges();
		test_point_counts();
		test_output_backpressure();
		test_random_phase(0, 0, 4'd9, 59);
		test_random_phase(60, 0, 4'd15, 59);
		test_random_phase(0, 60, 4'd0, 59);
		test_random_phase(6, 6, 4'($urandom_range(10, 1)), 59);
		drain_block();
		repeat (30) @(posedge clk);
		$display("checked %0d chars from %0d requests in %0d cycles, %0d mismatches", chars_checked,
			requests_sent, cycles, errors);
		$display("covered zoom and coordinate limits, point_chars 0, 1, 9, 10 and saturating");
		$display("counts, random traffic under idle and stall mixes and a long output hold");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### filelist.f
src/lgu_pkg.sv
src/latlon_geocode_url_prefix.sv
verif/tb_latlon_geocode_url_prefix.sv
